>>> rtl/tss_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tss_pkg
// Shared constants, codes and types of the triangular system solver.
// ----------------------------------------------------------------------------
package tss_pkg;

    localparam int MAX_ROWS  = 16;
    localparam int FRAC_BITS = 16;
    localparam int ROW_W     = $clog2(MAX_ROWS);
    localparam int CNT_W     = ROW_W + 1;
    localparam int ADDR_W    = 2 * ROW_W;
    localparam int DATA_W    = 32;
    localparam int ACC_W     = 64;
    localparam int QUO_W     = ACC_W + 1;
    localparam int LIMIT     = (MAX_ROWS < 16) ? MAX_ROWS : 16;

    localparam logic [1:0] MODE_COEF  = 2'd0;
    localparam logic [1:0] MODE_RHS   = 2'd1;
    localparam logic [1:0] MODE_SOLVE = 2'd2;

    localparam logic [1:0] CFG_UPPER = 2'd0;
    localparam logic [1:0] CFG_SIZE  = 2'd1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RHS_READ,
        ST_ACC_INIT,
        ST_MAC,
        ST_PIVOT,
        ST_PIVOT_WAIT,
        ST_DIV_START,
        ST_DIV_WAIT,
        ST_FINISH,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic              en;
        logic [ROW_W-1:0]  row;
        logic [DATA_W-1:0] val;
    } sol_write_t;

    typedef struct packed {
        logic              start;
        logic [ACC_W-1:0]  num;
        logic [DATA_W-1:0] den;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [QUO_W-1:0] quo;
    } div_rsp_t;

endpackage

>>> rtl/tss_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tss_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module tss_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> rtl/tss_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tss_cell
// One solution cell: holds one unknown, shifts it to its neighbor in the ring.
// ----------------------------------------------------------------------------
module tss_cell
    import tss_pkg::*;
(
    input  logic              clk,
    input  logic              shift,
    input  logic [DATA_W-1:0] shift_in,
    input  logic              wr_en,
    input  logic [DATA_W-1:0] wr_val,
    output logic [DATA_W-1:0] val
);

    logic [DATA_W-1:0] val_reg;

    always_ff @(posedge clk)
    begin
        if (shift)
        begin
            val_reg <= shift_in;
        end
        else if (wr_en)
        begin
            val_reg <= wr_val;
        end
    end

    assign val = val_reg;

endmodule

>>> rtl/tss_divider.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tss_divider
// Restoring unsigned divider, one quotient bit per cycle, round half up.
// ----------------------------------------------------------------------------
module tss_divider
    import tss_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);

    localparam int STEPS = ACC_W;
    localparam int CW    = $clog2(STEPS + 1);

    logic [CW-1:0]     cnt_reg;
    logic              busy_reg;
    logic              done_reg;
    logic [ACC_W-1:0]  num_reg;
    logic [ACC_W-1:0]  quo_reg;
    logic [DATA_W-1:0] rem_reg;
    logic [DATA_W-1:0] den_reg;
    logic [QUO_W-1:0]  q1_reg;

    logic [DATA_W:0] trial;
    logic [DATA_W:0] diff;
    logic            ge;
    logic            round_up;

    always_comb
    begin
        trial    = {rem_reg, num_reg[ACC_W-1]};
        diff     = trial - {1'b0, den_reg};
        ge       = (trial >= {1'b0, den_reg});
        round_up = ({rem_reg, 1'b0} >= {1'b0, den_reg});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= busy_reg && !req.start && (cnt_reg == CW'(STEPS));
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                if (cnt_reg == CW'(STEPS))
                begin
                    busy_reg <= 1'b0;
                end
                else
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            num_reg <= req.num;
            den_reg <= req.den;
            rem_reg <= '0;
            quo_reg <= '0;
        end
        else if (busy_reg)
        begin
            if (cnt_reg == CW'(STEPS))
            begin
                q1_reg <= {1'b0, quo_reg} + QUO_W'(round_up);
            end
            else
            begin
                rem_reg <= ge ? diff[DATA_W-1:0] : trial[DATA_W-1:0];
                quo_reg <= {quo_reg[ACC_W-2:0], ge};
                num_reg <= {num_reg[ACC_W-2:0], 1'b0};
            end
        end
    end

    assign rsp.done = done_reg;
    assign rsp.quo  = q1_reg;

endmodule

>>> rtl/triangular_system_solver_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// triangular_system_solver_unit
// Forward or back substitution on a Q16.16 triangular system.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_stall): mode 0 writes a coefficient, mode 1 a
// right-hand-side element, both with no result. Mode 2 starts a solve:
// in_stall stays high until the last row has been handed to the output
// register, so loads run at one per cycle while idle and a solve holds the
// channel. Each row rotates the ring through the multiply pipeline (one
// coefficient RAM read per cycle), passes setup and drain steps, and runs
// the bit-serial divider when the pivot is nonzero; a solve covers n rows.
// Results come out one per row through an output register
// (out_valid/out_stall); while the receiver stalls, the solve waits before
// emitting the next row. The last row carries last = 1.
// Configuration (cfg_valid/cfg_ready) is always ready; write it only while
// idle. Reset clears control state and sets size 16, forward direction;
// the stores hold no defined contents until written.
// ----------------------------------------------------------------------------
module triangular_system_solver_unit
    import tss_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [1:0]         mode,
    input  logic [3:0]         row,
    input  logic [3:0]         col,
    input  logic signed [31:0] value,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [3:0]         unknown_index,
    output logic signed [31:0] unknown_value,
    output logic               zero_pivot,
    output logic               overflowed,
    output logic               last,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [4:0]         cfg_data
);

    localparam logic [QUO_W-1:0] POS_LIM = QUO_W'(64'h7FFF_FFFF);
    localparam logic [QUO_W-1:0] NEG_LIM = QUO_W'(64'h8000_0000);
    localparam logic [DATA_W-1:0] V_MAX  = 32'h7FFF_FFFF;
    localparam logic [DATA_W-1:0] V_MIN  = 32'h8000_0000;

    state_t state_reg, state_next;

    logic             upper_reg;
    logic [4:0]       size_reg;
    logic [CNT_W-1:0] n_reg;
    logic [CNT_W-1:0] k_reg;
    logic [ROW_W-1:0] i_reg;
    logic [ROW_W-1:0] mac_cnt_reg;
    logic             out_valid_reg;

    // datapath
    logic signed [ACC_W-1:0]  acc_reg;
    logic                     acc_ov_reg;
    logic signed [DATA_W-1:0] x_s1_reg;
    logic                     s1_valid_reg;
    logic signed [ACC_W-1:0]  p_reg;
    logic                     p_valid_reg;
    logic [DATA_W-1:0]        d_reg;
    logic                     neg_reg;
    logic                     zp_reg;
    logic [DATA_W-1:0]        v_reg;
    logic                     ov_reg;
    logic [3:0]               o_index_reg;
    logic [DATA_W-1:0]        o_value_reg;
    logic                     o_zp_reg;
    logic                     o_ov_reg;
    logic                     o_last_reg;

    logic accept;
    logic out_free;
    logic row_last;
    logic mac_done;
    logic use_term;
    logic row_ok;
    logic col_ok;
    logic [CNT_W-1:0] n_start;

    // control decode
    logic              shift_en;
    logic [ADDR_W-1:0] coef_raddr;
    sol_write_t        sol_wr;
    div_req_t          div_req;
    div_rsp_t          div_rsp;

    logic [DATA_W-1:0] coef_rdata;
    logic [DATA_W-1:0] rhs_rdata;
    logic [DATA_W-1:0] cell_val [MAX_ROWS];

    logic [ACC_W:0]  acc_diff;
    logic [ACC_W-1:0] acc_mag;
    logic [DATA_W-1:0] d_mag;

    assign accept   = in_valid && !in_stall;
    assign out_free = !out_valid_reg || !out_stall;
    assign row_last = (k_reg == n_reg - 1'b1);
    assign mac_done = (mac_cnt_reg == ROW_W'(MAX_ROWS - 1));
    assign row_ok   = (32'(row) < MAX_ROWS);
    assign col_ok   = (32'(col) < MAX_ROWS);
    assign cfg_ready = 1'b1;

    always_comb
    begin
        if (size_reg == 5'd0)
        begin
            n_start = CNT_W'(1);
        end
        else if (32'(size_reg) > LIMIT)
        begin
            n_start = CNT_W'(LIMIT);
        end
        else
        begin
            n_start = CNT_W'(size_reg);
        end
    end

    always_comb
    begin
        if (upper_reg)
        begin
            use_term = (mac_cnt_reg > i_reg) && ({1'b0, mac_cnt_reg} < n_reg);
        end
        else
        begin
            use_term = (mac_cnt_reg < i_reg);
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && mode == MODE_SOLVE)
                begin
                    state_next = ST_RHS_READ;
                end
            end
            ST_RHS_READ:   state_next = ST_ACC_INIT;
            ST_ACC_INIT:   state_next = ST_MAC;
            ST_MAC:
            begin
                if (mac_done)
                begin
                    state_next = ST_PIVOT;
                end
            end
            ST_PIVOT:      state_next = ST_PIVOT_WAIT;
            ST_PIVOT_WAIT: state_next = ST_DIV_START;
            ST_DIV_START:
            begin
                state_next = (d_reg == '0) ? ST_FINISH : ST_DIV_WAIT;
            end
            ST_DIV_WAIT:
            begin
                if (div_rsp.done)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:     state_next = ST_EMIT;
            ST_EMIT:
            begin
                if (out_free)
                begin
                    state_next = row_last ? ST_IDLE : ST_RHS_READ;
                end
            end
            default:       state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        acc_mag = acc_reg[ACC_W-1] ? ACC_W'(-acc_reg) : ACC_W'(acc_reg);
        d_mag   = d_reg[DATA_W-1] ? DATA_W'(-d_reg) : d_reg;
    end

    // control outputs
    always_comb
    begin
        in_stall      = 1'b1;
        shift_en      = 1'b0;
        coef_raddr    = {i_reg, mac_cnt_reg};
        sol_wr.en     = 1'b0;
        sol_wr.row    = i_reg;
        sol_wr.val    = v_reg;
        div_req.start = 1'b0;
        div_req.num   = acc_mag;
        div_req.den   = d_mag;
        unique case (state_reg)
            ST_IDLE:      in_stall = 1'b0;
            ST_MAC:       shift_en = 1'b1;
            ST_PIVOT:     coef_raddr = {i_reg, i_reg};
            ST_DIV_START: div_req.start = (d_reg != '0);
            ST_EMIT:      sol_wr.en = out_free;
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            upper_reg     <= 1'b0;
            size_reg      <= 5'd16;
            n_reg         <= '0;
            k_reg         <= '0;
            i_reg         <= '0;
            mac_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
            s1_valid_reg  <= 1'b0;
            p_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    CFG_UPPER: upper_reg <= cfg_data[0];
                    CFG_SIZE:  size_reg  <= cfg_data;
                    default:
                    begin
                    end
                endcase
            end
            if (state_reg == ST_IDLE && accept && mode == MODE_SOLVE)
            begin
                n_reg <= n_start;
                k_reg <= '0;
                i_reg <= upper_reg ? ROW_W'(n_start - 1'b1) : '0;
            end
            if (state_reg == ST_MAC)
            begin
                mac_cnt_reg <= mac_cnt_reg + 1'b1;
            end
            else
            begin
                mac_cnt_reg <= '0;
            end
            s1_valid_reg <= (state_reg == ST_MAC) && use_term;
            p_valid_reg  <= s1_valid_reg;
            if (state_reg == ST_EMIT && out_free)
            begin
                out_valid_reg <= 1'b1;
                if (!row_last)
                begin
                    k_reg <= k_reg + 1'b1;
                    i_reg <= upper_reg ? i_reg - 1'b1 : i_reg + 1'b1;
                end
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign acc_diff = {acc_reg[ACC_W-1], acc_reg} - {p_reg[ACC_W-1], p_reg};

    always_ff @(posedge clk)
    begin
        x_s1_reg <= cell_val[0];
        p_reg    <= $signed(coef_rdata) * x_s1_reg;
        if (state_reg == ST_ACC_INIT)
        begin
            acc_reg    <= $signed({{(ACC_W-DATA_W){rhs_rdata[DATA_W-1]}}, rhs_rdata})
                          <<< FRAC_BITS;
            acc_ov_reg <= 1'b0;
        end
        else if (p_valid_reg)
        begin
            // saturate at the 64-bit bounds
            if (acc_diff[ACC_W] != acc_diff[ACC_W-1])
            begin
                acc_reg    <= acc_diff[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}}
                                              : {1'b0, {(ACC_W-1){1'b1}}};
                acc_ov_reg <= 1'b1;
            end
            else
            begin
                acc_reg <= $signed(acc_diff[ACC_W-1:0]);
            end
        end
        if (state_reg == ST_PIVOT_WAIT)
        begin
            d_reg <= coef_rdata;
        end
        if (state_reg == ST_DIV_START)
        begin
            neg_reg <= acc_reg[ACC_W-1] ^ d_reg[DATA_W-1];
            zp_reg  <= (d_reg == '0);
        end
        if (state_reg == ST_FINISH)
        begin
            if (zp_reg)
            begin
                ov_reg <= acc_ov_reg;
                if (acc_reg == '0)
                begin
                    v_reg <= '0;
                end
                else
                begin
                    v_reg <= acc_reg[ACC_W-1] ? V_MIN : V_MAX;
                end
            end
            else if (neg_reg)
            begin
                ov_reg <= acc_ov_reg || (div_rsp.quo > NEG_LIM);
                v_reg  <= (div_rsp.quo > NEG_LIM) ? V_MIN
                                                  : DATA_W'(-div_rsp.quo[DATA_W-1:0]);
            end
            else
            begin
                ov_reg <= acc_ov_reg || (div_rsp.quo > POS_LIM);
                v_reg  <= (div_rsp.quo > POS_LIM) ? V_MAX : div_rsp.quo[DATA_W-1:0];
            end
        end
        if (state_reg == ST_EMIT && out_free)
        begin
            o_index_reg <= 4'(i_reg);
            o_value_reg <= v_reg;
            o_zp_reg    <= zp_reg;
            o_ov_reg    <= ov_reg;
            o_last_reg  <= row_last;
        end
    end

    tss_ram #(
        .WIDTH (DATA_W),
        .DEPTH (MAX_ROWS * MAX_ROWS)
    ) u_coef_ram (
        .clk   (clk),
        .we    (accept && mode == MODE_COEF && row_ok && col_ok),
        .waddr ({ROW_W'(row), ROW_W'(col)}),
        .wdata (value),
        .raddr (coef_raddr),
        .rdata (coef_rdata)
    );

    tss_ram #(
        .WIDTH (DATA_W),
        .DEPTH (MAX_ROWS)
    ) u_rhs_ram (
        .clk   (clk),
        .we    (accept && mode == MODE_RHS && row_ok),
        .waddr (ROW_W'(row)),
        .wdata (value),
        .raddr (i_reg),
        .rdata (rhs_rdata)
    );

    // ring of solution cells; after a full rotation cell k holds unknown k
    for (genvar k = 0; k < MAX_ROWS; k++)
    begin : g_cell
        tss_cell u_cell (
            .clk      (clk),
            .shift    (shift_en),
            .shift_in (cell_val[(k + 1) % MAX_ROWS]),
            .wr_en    (sol_wr.en && sol_wr.row == ROW_W'(k)),
            .wr_val   (sol_wr.val),
            .val      (cell_val[k])
        );
    end

    tss_divider u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    assign out_valid     = out_valid_reg;
    assign unknown_index = o_index_reg;
    assign unknown_value = $signed(o_value_reg);
    assign zero_pivot    = o_zp_reg;
    assign overflowed    = o_ov_reg;
    assign last          = o_last_reg;

endmodule

>>> rtl/tss_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tss_checker
// Port-level checks of the triangular system solver, bound to the top level.
// ----------------------------------------------------------------------------
module tss_checker
    import tss_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic [1:0]  mode,
    input logic        out_valid,
    input logic        out_stall,
    input logic [3:0]  unknown_index,
    input logic [31:0] unknown_value,
    input logic        zero_pivot,
    input logic        last
);

    // hold a stalled result
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(unknown_value)
                                  && $stable(unknown_index))
        else $error("stalled result changed");

    // a solve request blocks the next request
    a_solve_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && mode == MODE_SOLVE |=> in_stall)
        else $error("request accepted right after solve");

    // a non-final result means the run is still going
    a_run_open: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && !last |-> in_stall)
        else $error("input open before run ended");

    a_zp_value: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && zero_pivot |-> unknown_value == 32'h7FFF_FFFF
                                   || unknown_value == 32'h8000_0000
                                   || unknown_value == 32'h0)
        else $error("zero pivot value not saturated or zero");

endmodule

bind triangular_system_solver_unit tss_checker u_tss_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .mode          (mode),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .unknown_index (unknown_index),
    .unknown_value (unknown_value),
    .zero_pivot    (zero_pivot),
    .last          (last)
);

>>> bench/triangular_system_solver_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// triangular_system_solver_unit_tb
// Loads coefficient and right-hand-side entries, starts forward and back
// solves over several sizes, and checks every solution element against a
// fixed-point substitution predictor under random idling and stalling.
// ----------------------------------------------------------------------------
module triangular_system_solver_unit_tb;
    import tss_pkg::*;

    localparam logic [1:0] MODE_NONE = 2'd3;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int HOLD_CYCLES    = 300;

    typedef struct {
        logic [3:0]  idx;
        logic [31:0] val;
        logic        zp;
        logic        ov;
        logic        lst;
    } solution_t;

    class solution_scoreboard;
        logic signed [31:0] coef [16][16];
        logic signed [31:0] rhs [16];
        logic signed [31:0] sol [16];
        logic               upper;
        logic [4:0]         size;
        solution_t          waiting [$];
        int                 errors;

        function new();
            upper  = 1'b0;
            size   = 5'd16;
            errors = 0;
        endfunction

        task report(string msg);
            $display("mismatch: %s", msg);
            errors++;
        endtask

        function void set_reg(logic [1:0] idx, logic [4:0] data);
            if (idx == CFG_UPPER)
                upper = data[0];
            else if (idx == CFG_SIZE)
                size = data;
        endfunction

        // Subtract a product from the accumulator, saturating at 64 bits.
        function longint acc_sub(longint a, longint p, inout bit ov);
            logic signed [64:0] t;
            t = {a[63], a} - {p[63], p};
            if (t[64] != t[63])
            begin
                ov = 1;
                return t[64] ? 64'sh8000_0000_0000_0000 : 64'sh7FFF_FFFF_FFFF_FFFF;
            end
            return t[63:0];
        endfunction

        function logic [31:0] quotient(longint a, logic signed [31:0] d, inout bit ov);
            bit [63:0] na, nd, q, r;
            longint    dl;
            bit        neg;
            dl  = d;
            na  = (a < 0) ? 64'(-a) : 64'(a);
            nd  = (dl < 0) ? 64'(-dl) : 64'(dl);
            q   = na / nd;
            r   = na % nd;
            neg = (a < 0) != (d < 0);
            if (r >= nd - r)
                q++;
            if (!neg)
            begin
                if (q > 64'h7FFF_FFFF)
                begin
                    ov = 1;
                    return 32'h7FFF_FFFF;
                end
                return q[31:0];
            end
            if (q > 64'h8000_0000)
            begin
                ov = 1;
                return 32'h8000_0000;
            end
            return 32'(-q);
        endfunction

        function void note_input(logic [1:0] m, logic [3:0] r, logic [3:0] c,
                                 logic signed [31:0] v);
            int        n, i, lo, hi;
            longint    acc;
            bit        ov;
            solution_t e;
            if (m == MODE_COEF)
                coef[r][c] = v;
            else if (m == MODE_RHS)
                rhs[r] = v;
            else if (m == MODE_SOLVE)
            begin
                n = (size == 0) ? 1 : ((size > 16) ? 16 : int'(size));
                for (int k = 0; k < n; k++)
                begin
                    i   = upper ? n - 1 - k : k;
                    acc = longint'(rhs[i]) * 64'sd65536;
                    ov  = 0;
                    lo  = upper ? i + 1 : 0;
                    hi  = upper ? n : i;
                    for (int j = lo; j < hi; j++)
                        acc = acc_sub(acc, longint'(coef[i][j]) * longint'(sol[j]), ov);
                    e.zp = (coef[i][i] == 0);
                    if (e.zp)
                        e.val = (acc > 0) ? 32'h7FFF_FFFF : ((acc < 0) ? 32'h8000_0000 : 32'h0);
                    else
                        e.val = quotient(acc, coef[i][i], ov);
                    sol[i] = e.val;
                    e.idx  = i[3:0];
                    e.ov   = ov;
                    e.lst  = (k == n - 1);
                    waiting = {waiting, e};
                end
            end
        endfunction

        task check(solution_t got);
            solution_t e;
            if (waiting.size() == 0)
            begin
                report($sformatf("unexpected element index %0d", got.idx));
                return;
            end
            e = waiting.pop_front();
            if (got.idx !== e.idx)
                report($sformatf("index got %0d exp %0d", got.idx, e.idx));
            if (got.val !== e.val)
                report($sformatf("row %0d value got %h exp %h", e.idx, got.val, e.val));
            if (got.zp !== e.zp)
                report($sformatf("row %0d zero_pivot got %b exp %b", e.idx, got.zp, e.zp));
            if (got.ov !== e.ov)
                report($sformatf("row %0d overflowed got %b exp %b", e.idx, got.ov, e.ov));
            if (got.lst !== e.lst)
                report($sformatf("row %0d last got %b exp %b", e.idx, got.lst, e.lst));
        endtask
    endclass

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    logic [1:0]         mode;
    logic [3:0]         row;
    logic [3:0]         col;
    logic signed [31:0] value;
    logic               out_valid;
    logic               out_stall;
    logic [3:0]         unknown_index;
    logic signed [31:0] unknown_value;
    logic               zero_pivot;
    logic               overflowed;
    logic               last;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [1:0]         cfg_index;
    logic [4:0]         cfg_data;

    solution_scoreboard sb = new();
    bit  quiet;
    bit  hold_req;
    int  hold_left;
    int  items;
    int  idle_cycles;
    bit  coef_w [16][16];
    bit  rhs_w [16];

    triangular_system_solver_unit u_top (.*);

    initial clk = 1'b0;
    always #5 clk = ~clk;

    task automatic send(logic [1:0] m, logic [3:0] r, logic [3:0] c, logic [31:0] v);
        while (!quiet && $urandom_range(0, 99) < 17)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        mode     <= m;
        row      <= r;
        col      <= c;
        value    <= v;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sb.note_input(m, r, c, v);
        if (m == MODE_COEF)
            coef_w[r][c] = 1;
        if (m == MODE_RHS)
            rhs_w[r] = 1;
        if (m != MODE_NONE)
            items++;
    endtask

    // Write both registers once the block has drained.
    task automatic configure(logic up, logic [4:0] sz);
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.waiting.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        for (int k = 0; k < 2; k++)
        begin
            cfg_valid <= 1'b1;
            cfg_index <= (k == 0) ? CFG_UPPER : CFG_SIZE;
            cfg_data  <= (k == 0) ? {4'd0, up} : sz;
            @(posedge clk);
            while (!cfg_ready)
                @(posedge clk);
            sb.set_reg((k == 0) ? CFG_UPPER : CFG_SIZE, (k == 0) ? {4'd0, up} : sz);
        end
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [31:0] pick_value(bit diag);
        case ($urandom_range(0, 9))
            0: return diag ? 32'h0 : $urandom;
            1: return $urandom;
            2: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            default: return diag ? ($urandom_range(0, 1) ? 32'h0001_0000 + $urandom_range(0, 'h20000)
                                                          : 32'hFFFF_0000 - $urandom_range(0, 'h20000))
                                 : 32'($urandom_range(0, 'h20000)) - 32'h10000;
        endcase
    endfunction

    // Load what a solve of this shape reads, with some noise, then start it.
    task automatic solve_set(logic up, logic [4:0] sz, int extra);
        int n, lo, hi;
        n = (sz == 0) ? 1 : ((sz > 16) ? 16 : int'(sz));
        configure(up, sz);
        for (int i = 0; i < n; i++)
        begin
            lo = up ? i : 0;
            hi = up ? n - 1 : i;
            for (int j = lo; j <= hi; j++)
            begin
                if (!coef_w[i][j] || $urandom_range(0, 1))
                    send(MODE_COEF, 4'(i), 4'(j), pick_value(i == j));
                if ($urandom_range(0, 5) == 0)
                    send($urandom_range(0, 3) == 0 ? MODE_NONE : MODE_COEF,
                         4'($urandom), 4'($urandom), $urandom);
            end
            if (!rhs_w[i] || $urandom_range(0, 1))
                send(MODE_RHS, 4'(i), 4'($urandom), pick_value(0));
        end
        send(MODE_SOLVE, 4'($urandom), 4'($urandom), $urandom);
        // hold the result side while loads keep waiting on the solve
        if (extra > 0)
            hold_req = 1;
        for (int k = 0; k < extra; k++)
            send(MODE_COEF, 4'($urandom), 4'($urandom), $urandom);
    endtask

    // result side: random stalls plus one long hold on request
    initial
    begin
        solution_t got;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && !out_stall)
            begin
                got.idx = unknown_index;
                got.val = unknown_value;
                got.zp  = zero_pivot;
                got.ov  = overflowed;
                got.lst = last;
                sb.check(got);
            end
            if (hold_req)
            begin
                hold_req  = 0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else
                out_stall <= !quiet && ($urandom_range(0, 99) < 17);
        end
    end

    initial
    begin
        forever
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("[triangular_system_solver_unit] ERROR");
                $finish;
            end
        end
    end

    initial
    begin
        int set_no;
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        mode      = MODE_COEF;
        row       = '0;
        col       = '0;
        value     = '0;
        out_stall = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = CFG_UPPER;
        cfg_data  = '0;
        quiet     = 0;
        hold_req  = 0;
        hold_left = 0;
        items     = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // single row: unit pivot, then zero pivot with positive, negative, zero rhs
        configure(1'b0, 5'd1);
        send(MODE_COEF, 0, 0, 32'h0001_0000);
        send(MODE_RHS, 0, 0, 32'h7FFF_FFFF);
        send(MODE_SOLVE, 0, 0, 0);
        send(MODE_COEF, 0, 0, 32'h0);
        send(MODE_SOLVE, 0, 0, 0);
        send(MODE_RHS, 0, 0, 32'h8000_0000);
        send(MODE_SOLVE, 0, 0, 0);
        send(MODE_RHS, 0, 0, 32'h0);
        send(MODE_NONE, 4'hF, 4'hF, 32'hFFFF_FFFF);
        send(MODE_SOLVE, 0, 0, 0);
        // tiny pivot makes the quotient overflow
        send(MODE_COEF, 0, 0, 32'h0000_0001);
        send(MODE_RHS, 0, 0, 32'h7FFF_FFFF);
        send(MODE_SOLVE, 0, 0, 0);
        // size 0 counts as one row
        configure(1'b1, 5'd0);
        send(MODE_COEF, 0, 0, 32'hFFFF_0000);
        send(MODE_SOLVE, 0, 0, 0);
        // two rows, back substitution, quotients overflow
        configure(1'b1, 5'd2);
        send(MODE_COEF, 1, 1, 32'h0000_0001);
        send(MODE_RHS, 1, 0, 32'h7FFF_FFFF);
        send(MODE_COEF, 0, 1, 32'h8000_0000);
        send(MODE_COEF, 0, 0, 32'h7FFF_FFFF);
        send(MODE_RHS, 0, 0, 32'h7FFF_FFFF);
        send(MODE_SOLVE, 0, 0, 0);

        set_no = 0;
        while (items < 210)
        begin
            quiet = (set_no >= 8 && set_no < 12);
            if (set_no == 2)
                solve_set(1'b0, 5'd16, 0);
            else if (set_no == 6)
                solve_set(1'b1, 5'd31, 0);
            else if (set_no == 4)
                solve_set(1'($urandom_range(0, 1)), 5'd4, 6);
            else
                solve_set(1'($urandom_range(0, 1)),
                          ($urandom_range(0, 7) == 0) ? 5'd0 : 5'($urandom_range(1, 4)), 0);
            set_no++;
        end
        quiet = 0;
        in_valid <= 1'b0;
        while (sb.waiting.size() != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
        if (sb.errors == 0)
            $display("[triangular_system_solver_unit] OK");
        else
            $display("[triangular_system_solver_unit] ERROR");
        $finish;
    end

endmodule
